>>> design/bmp_dfr_pkg.sv
// Shared types and constants for the BMP 24-bit pixel deframer.
`default_nettype none
package bmp_dfr_pkg;

    // Width of the reported image dimensions
    localparam int DIM_W = 13;

    // Depth of the result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;

    // File signature bytes "BM"
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Byte positions that complete each header field
    localparam logic [15:0] POS_OFFSET_END = 16'd13;
    localparam logic [15:0] POS_WIDTH_END  = 16'd21;
    localparam logic [15:0] POS_HEIGHT_END = 16'd25;
    localparam logic [15:0] POS_DEPTH_END  = 16'd29;

    // Smallest legal pixel data offset; header ends here
    localparam logic [31:0] MIN_OFFSET = 32'd30;

    typedef enum logic [1:0] {
        ST_PIXEL   = 2'd0,
        ST_HEADER  = 2'd1,
        ST_BAD_SIG = 2'd2,
        ST_BAD_HDR = 2'd3
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [15:0]      bit_depth;
        logic             last_pixel;
    } t_result;

endpackage
`default_nettype wire

>>> design/bmp_dfr_front.sv
// Byte parser: header capture, offset skip, pixel assembly, row padding.
`default_nettype none
module bmp_dfr_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_OFFSET = 65535
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_file_start,
    output logic                      o_push,
    output bmp_dfr_pkg::t_result      o_result
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam logic [31:0] LIM_W   = 32'(MAX_WIDTH);
    localparam logic [31:0] LIM_H   = 32'(MAX_HEIGHT);
    localparam logic [31:0] LIM_OFF = 32'(MAX_OFFSET);

    typedef enum logic [5:0] {
        PH_SIG    = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_PIXEL  = 6'b001000,
        PH_PAD    = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    t_phase        r_phase,  n_phase,  c_phase;
    logic [15:0]   r_pos,    n_pos,    c_pos;
    logic [31:0]   r_fa,     n_fa,     c_fa;
    logic [15:0]   r_offset, n_offset, c_offset;
    logic [WW-1:0] r_width,  n_width,  c_width;
    logic [HW-1:0] r_height, n_height, c_height;
    logic [WW-1:0] r_col,    n_col,    c_col;
    logic [HW-1:0] r_row,    n_row,    c_row;
    logic [1:0]    r_chan,   n_chan,   c_chan;
    logic [15:0]   r_held,   n_held,   c_held;
    logic [1:0]    r_pad,    n_pad,    c_pad;

    logic [31:0]   fa_new;
    logic [31:0]   w32;
    logic [31:0]   h32;
    logic [WW:0]   col_inc;
    logic [HW:0]   row_inc;
    logic [16:0]   pos_inc;

    always_comb begin
        // file_start restarts parsing with this byte as byte 0
        c_phase  = i_file_start ? PH_SIG : r_phase;
        c_pos    = i_file_start ? '0 : r_pos;
        c_fa     = i_file_start ? '0 : r_fa;
        c_offset = i_file_start ? '0 : r_offset;
        c_width  = i_file_start ? '0 : r_width;
        c_height = i_file_start ? '0 : r_height;
        c_col    = i_file_start ? '0 : r_col;
        c_row    = i_file_start ? '0 : r_row;
        c_chan   = i_file_start ? '0 : r_chan;
        c_held   = i_file_start ? '0 : r_held;
        c_pad    = i_file_start ? '0 : r_pad;

        n_phase  = c_phase;
        n_pos    = c_pos;
        n_fa     = c_fa;
        n_offset = c_offset;
        n_width  = c_width;
        n_height = c_height;
        n_col    = c_col;
        n_row    = c_row;
        n_chan   = c_chan;
        n_held   = c_held;
        n_pad    = c_pad;

        fa_new  = {i_data_byte, c_fa[31:8]};
        w32     = 32'(c_width);
        h32     = 32'(c_height);
        col_inc = {1'b0, c_col} + {{WW{1'b0}}, 1'b1};
        row_inc = {1'b0, c_row} + {{HW{1'b0}}, 1'b1};
        pos_inc = {1'b0, c_pos} + 17'd1;

        o_push   = 1'b0;
        o_result = '0;

        case (c_phase)
            PH_SIG: begin
                if ((c_pos == 16'd0 && i_data_byte != bmp_dfr_pkg::SIG_B) ||
                    (c_pos != 16'd0 && i_data_byte != bmp_dfr_pkg::SIG_M)) begin
                    n_phase         = PH_DONE;
                    o_push          = 1'b1;
                    o_result.status = bmp_dfr_pkg::ST_BAD_SIG;
                end else begin
                    n_pos = pos_inc[15:0];
                    if (c_pos != 16'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                n_fa  = fa_new;
                n_pos = pos_inc[15:0];
                case (c_pos)
                    bmp_dfr_pkg::POS_OFFSET_END: begin
                        if (fa_new < bmp_dfr_pkg::MIN_OFFSET || fa_new > LIM_OFF) begin
                            n_phase         = PH_DONE;
                            o_push          = 1'b1;
                            o_result.status = bmp_dfr_pkg::ST_BAD_HDR;
                        end else begin
                            n_offset = fa_new[15:0];
                        end
                    end
                    bmp_dfr_pkg::POS_WIDTH_END: begin
                        if (fa_new > LIM_W) begin
                            n_phase         = PH_DONE;
                            o_push          = 1'b1;
                            o_result.status = bmp_dfr_pkg::ST_BAD_HDR;
                        end else begin
                            n_width = fa_new[WW-1:0];
                        end
                    end
                    bmp_dfr_pkg::POS_HEIGHT_END: begin
                        if (fa_new > LIM_H) begin
                            n_phase         = PH_DONE;
                            o_push          = 1'b1;
                            o_result.status = bmp_dfr_pkg::ST_BAD_HDR;
                        end else begin
                            n_height = fa_new[HW-1:0];
                        end
                    end
                    bmp_dfr_pkg::POS_DEPTH_END: begin
                        n_col  = '0;
                        n_row  = '0;
                        n_chan = '0;
                        n_held = '0;
                        if (c_width == '0 || c_height == '0) begin
                            n_phase = PH_DONE;
                        end else if (32'(c_offset) <= bmp_dfr_pkg::MIN_OFFSET) begin
                            n_phase = PH_PIXEL;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                        o_push                = 1'b1;
                        o_result.status       = bmp_dfr_pkg::ST_HEADER;
                        o_result.image_width  = w32[bmp_dfr_pkg::DIM_W-1:0];
                        o_result.image_height = h32[bmp_dfr_pkg::DIM_W-1:0];
                        o_result.bit_depth    = fa_new[31:16];
                    end
                    default: begin
                    end
                endcase
            end
            PH_SKIP: begin
                n_pos = pos_inc[15:0];
                if (pos_inc >= {1'b0, c_offset}) begin
                    n_phase = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                case (c_chan)
                    2'd0: begin
                        n_held = {8'd0, i_data_byte};
                        n_chan = 2'd1;
                    end
                    2'd1: begin
                        n_held = {i_data_byte, c_held[7:0]};
                        n_chan = 2'd2;
                    end
                    default: begin
                        n_chan              = 2'd0;
                        o_push              = 1'b1;
                        o_result.status     = bmp_dfr_pkg::ST_PIXEL;
                        o_result.red        = i_data_byte;
                        o_result.green      = c_held[15:8];
                        o_result.blue       = c_held[7:0];
                        o_result.alpha      = bmp_dfr_pkg::ALPHA_OPAQUE;
                        o_result.last_pixel = (col_inc == {1'b0, c_width}) &&
                                              (row_inc == {1'b0, c_height});
                        n_col = col_inc[WW-1:0];
                        if (col_inc >= {1'b0, c_width}) begin
                            // end of row; pad bytes equal width mod 4
                            n_col = '0;
                            n_row = row_inc[HW-1:0];
                            if (row_inc >= {1'b0, c_height}) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_pad   = w32[1:0];
                                n_phase = (w32[1:0] != 2'd0) ? PH_PAD : PH_PIXEL;
                            end
                        end
                    end
                endcase
            end
            PH_PAD: begin
                n_pad = (c_pad != 2'd0) ? c_pad - 2'd1 : c_pad;
                if (n_pad == 2'd0) begin
                    n_phase = PH_PIXEL;
                end
            end
            default: begin
            end
        endcase

        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIG;
            r_pos    <= '0;
            r_fa     <= '0;
            r_offset <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_chan   <= '0;
            r_held   <= '0;
            r_pad    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_fa     <= n_fa;
            r_offset <= n_offset;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_chan   <= n_chan;
            r_held   <= n_held;
            r_pad    <= n_pad;
        end
    end

endmodule
`default_nettype wire

>>> design/bmp_dfr_queue.sv
// Small result FIFO between the parser and the output stage.
`default_nettype none
module bmp_dfr_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire bmp_dfr_pkg::t_result i_data,
    input  wire logic                 i_pop,
    output bmp_dfr_pkg::t_result      o_head,
    output logic                      o_nonempty,
    output logic                      o_full
);

    localparam int QW = $clog2(bmp_dfr_pkg::QUEUE_DEPTH);

    bmp_dfr_pkg::t_result r_mem [bmp_dfr_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QW:0]   r_count,  n_count;

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_full     = (r_count == (QW+1)'(bmp_dfr_pkg::QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (QW+1)'(1);
            2'b01:   n_count = r_count - (QW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> design/bmp_dfr_back.sv
// Output register stage: drains the result queue under downstream stall.
`default_nettype none
module bmp_dfr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bmp_dfr_pkg::t_result i_head,
    input  wire logic                 i_head_valid,
    output logic                      o_pop,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output bmp_dfr_pkg::t_result      o_result
);

    logic                 r_valid;
    bmp_dfr_pkg::t_result r_result;

    // Load a new beat whenever the register is empty or being taken
    assign o_pop    = i_head_valid && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_head_valid;
        end
    end

endmodule
`default_nettype wire

>>> design/bmp_rgb24_pixel_deframer.sv
// Top level: one byte per cycle in, at most one result beat per byte out.
// Throughput: one input byte per cycle, sustained while the output is not stalled.
// A result beat goes into the queue memory at the edge that accepts its byte, then into the output register.
// The 4-entry result queue plus the output register hold up to 5 waiting results.
// Reset (synchronous, active low) empties the queue and restarts at the signature.
`default_nettype none
module bmp_rgb24_pixel_deframer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_OFFSET = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_file_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [12:0]      o_image_width,
    output logic [12:0]      o_image_height,
    output logic [15:0]      o_bit_depth,
    output logic             o_last_pixel
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 q_nonempty;
    logic                 q_full;
    bmp_dfr_pkg::t_result front_result;
    bmp_dfr_pkg::t_result q_head;
    bmp_dfr_pkg::t_result out_result;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    bmp_dfr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_OFFSET (MAX_OFFSET)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_push       (push),
        .o_result     (front_result)
    );

    bmp_dfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (front_result),
        .i_pop      (pop),
        .o_head     (q_head),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    bmp_dfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (q_nonempty),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_status       = out_result.status;
    assign o_red          = out_result.red;
    assign o_green        = out_result.green;
    assign o_blue         = out_result.blue;
    assign o_alpha        = out_result.alpha;
    assign o_image_width  = out_result.image_width;
    assign o_image_height = out_result.image_height;
    assign o_bit_depth    = out_result.bit_depth;
    assign o_last_pixel   = out_result.last_pixel;

endmodule
`default_nettype wire
